### rtl/hbfc_pkg.sv
// Shared constants and types for the HLL boundary flux correction pipeline.
`timescale 1ns / 1ps

package hbfc_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic FORM_WEAK   = 1'b0;
    localparam logic FORM_STRONG = 1'b1;

    localparam int USER_DEGENERATE = 0;
    localparam int USER_SATURATED  = 1;
    localparam int USER_W          = 2;

    typedef struct packed {
        logic neg;
        logic degenerate;
        logic sat;
    } hbfc_flags_t;

endpackage

### rtl/hbfc_front.sv
// Front pipeline: wave speed bounds, products, numerator, magnitude and clip test.
`timescale 1ns / 1ps

module hbfc_front #(
    parameter int WORD_BITS = hbfc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = hbfc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic                                   formulation,
    input  logic signed [WORD_BITS-1:0]            state_inside,
    input  logic signed [WORD_BITS-1:0]            state_outside,
    input  logic signed [WORD_BITS-1:0]            flux_inside,
    input  logic signed [WORD_BITS-1:0]            flux_outside,
    input  logic signed [WORD_BITS-1:0]            out_speed_inside,
    input  logic signed [WORD_BITS-1:0]            in_speed_inside,
    input  logic signed [WORD_BITS-1:0]            out_speed_outside,
    input  logic signed [WORD_BITS-1:0]            in_speed_outside,
    output logic                                   out_valid,
    output logic [WORD_BITS+FRAC_BITS+1:0]         out_rem,
    output logic [WORD_BITS-1:0]                   out_low,
    output logic [WORD_BITS+FRAC_BITS:0]           out_ds,
    output hbfc_pkg::hbfc_flags_t                  out_flags
);
    import hbfc_pkg::*;

    localparam int W1     = WORD_BITS + 1;
    localparam int PW     = 2 * WORD_BITS + 2;
    localparam int NA     = 2 * WORD_BITS + FRAC_BITS;
    localparam int NB     = 3 * WORD_BITS - 2;
    localparam int NW     = ((NA > NB) ? NA : NB) + 2;
    localparam int DSW    = WORD_BITS + FRAC_BITS + 1;
    localparam int RW     = WORD_BITS + FRAC_BITS + 2;
    localparam int LW     = DSW + WORD_BITS;
    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;

    // stage 1: speed bounds, state difference, flux operand selection
    logic signed [W1-1:0] os_in_x, neg_is_ex, neg_is_in, os_ex_x;
    logic signed [W1-1:0] lmax_lo, lmax_c, nmin_lo, nmin_c;
    logic signed [W1-1:0] f_in_x, f_ex_x, du_c, fa_c, fb_c;

    logic [WORD_BITS-1:0]        s1_lmax_reg, s1_nmin_reg;
    logic signed [W1-1:0]        s1_du_reg, s1_fa_reg, s1_fb_reg;

    logic signed [PW-1:0]        s2_ma_reg, s2_mb_reg;
    logic [2*WORD_BITS-1:0]      s2_pp_reg;
    logic [W1-1:0]               s2_d_reg;
    logic signed [W1-1:0]        s2_du_reg;

    logic signed [PW-1:0]        s3_flux_reg, s3_plo_reg, s3_phi_reg;
    logic [W1-1:0]               s3_d_reg;

    logic signed [NW-1:0]        s4_ppdu_reg;
    logic signed [PW-1:0]        s4_flux_reg;
    logic [W1-1:0]               s4_d_reg;

    logic signed [NW-1:0]        s5_num_reg;
    logic [DSW-1:0]              s5_ds_reg;
    logic                        s5_deg_reg;

    logic                        s6_neg_reg, s6_deg_reg;
    logic [NW-1:0]               s6_mag_reg;
    logic [LW-1:0]               s6_lim_reg;
    logic [DSW-1:0]              s6_ds_reg;

    logic [RW-1:0]               s7_rem_reg;
    logic [WORD_BITS-1:0]        s7_low_reg;
    logic [DSW-1:0]              s7_ds_reg;
    hbfc_flags_t                 s7_flags_reg;

    always_comb begin
        os_in_x   = W1'(out_speed_inside);
        os_ex_x   = W1'(out_speed_outside);
        neg_is_ex = -W1'(in_speed_outside);
        neg_is_in = -W1'(in_speed_inside);
        lmax_lo   = os_in_x[WORD_BITS] ? '0 : os_in_x;
        lmax_c    = (neg_is_ex > lmax_lo) ? neg_is_ex : lmax_lo;
        nmin_lo   = os_ex_x[WORD_BITS] ? '0 : os_ex_x;
        nmin_c    = (neg_is_in > nmin_lo) ? neg_is_in : nmin_lo;
        f_in_x    = W1'(flux_inside);
        f_ex_x    = W1'(flux_outside);
        du_c      = W1'(state_outside) - W1'(state_inside);
        if (formulation == FORM_STRONG) begin
            fa_c = '0;
            fb_c = f_in_x + f_ex_x;
        end else begin
            fa_c = f_in_x;
            fb_c = f_ex_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_lmax_reg <= lmax_c[WORD_BITS-1:0];
            s1_nmin_reg <= nmin_c[WORD_BITS-1:0];
            s1_du_reg   <= du_c;
            s1_fa_reg   <= fa_c;
            s1_fb_reg   <= fb_c;

            s2_ma_reg   <= $signed({1'b0, s1_lmax_reg}) * s1_fa_reg;
            s2_mb_reg   <= $signed({1'b0, s1_nmin_reg}) * s1_fb_reg;
            s2_pp_reg   <= s1_lmax_reg * s1_nmin_reg;
            s2_d_reg    <= {1'b0, s1_lmax_reg} + {1'b0, s1_nmin_reg};
            s2_du_reg   <= s1_du_reg;

            s3_flux_reg <= s2_ma_reg - s2_mb_reg;
            s3_plo_reg  <= $signed({1'b0, s2_pp_reg[WORD_BITS-1:0]}) * s2_du_reg;
            s3_phi_reg  <= $signed({1'b0, s2_pp_reg[2*WORD_BITS-1:WORD_BITS]}) * s2_du_reg;
            s3_d_reg    <= s2_d_reg;

            s4_ppdu_reg <= (NW'(s3_phi_reg) <<< WORD_BITS) + NW'(s3_plo_reg);
            s4_flux_reg <= s3_flux_reg;
            s4_d_reg    <= s3_d_reg;

            // lmax*lmin = -lmax*nmin, so the state term is subtracted
            s5_num_reg  <= (NW'(s4_flux_reg) <<< FRAC_BITS) - s4_ppdu_reg;
            s5_ds_reg   <= DSW'(s4_d_reg) << FRAC_BITS;
            s5_deg_reg  <= (s4_d_reg == '0);

            s6_neg_reg  <= s5_num_reg[NW-1];
            s6_mag_reg  <= s5_num_reg[NW-1] ? NW'(-s5_num_reg) : NW'(s5_num_reg);
            s6_lim_reg  <= (LW'(s5_ds_reg) << (WORD_BITS - 1))
                           + (s5_num_reg[NW-1] ? LW'(s5_ds_reg) : LW'(0));
            s6_ds_reg   <= s5_ds_reg;
            s6_deg_reg  <= s5_deg_reg;

            s7_rem_reg            <= s6_mag_reg[WORD_BITS +: RW];
            s7_low_reg            <= s6_mag_reg[WORD_BITS-1:0];
            s7_ds_reg             <= s6_ds_reg;
            s7_flags_reg.neg      <= s6_neg_reg;
            s7_flags_reg.degenerate <= s6_deg_reg;
            s7_flags_reg.sat      <= !s6_deg_reg && (s6_mag_reg >= NW'(s6_lim_reg));
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_rem   = s7_rem_reg;
    assign out_low   = s7_low_reg;
    assign out_ds    = s7_ds_reg;
    assign out_flags = s7_flags_reg;

endmodule

### rtl/hbfc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module hbfc_div #(
    parameter int WORD_BITS = hbfc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = hbfc_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [WORD_BITS+FRAC_BITS+1:0] in_rem,
    input  logic [WORD_BITS-1:0]           in_low,
    input  logic [WORD_BITS+FRAC_BITS:0]   in_ds,
    input  hbfc_pkg::hbfc_flags_t          in_flags,
    output logic                           out_valid,
    output logic [WORD_BITS-1:0]           out_quo,
    output hbfc_pkg::hbfc_flags_t          out_flags
);
    import hbfc_pkg::*;

    localparam int DSW = WORD_BITS + FRAC_BITS + 1;
    localparam int RW  = WORD_BITS + FRAC_BITS + 2;

    logic [WORD_BITS-1:0] vld_reg;
    logic [RW-1:0]        rem_reg [WORD_BITS];
    logic [WORD_BITS-1:0] low_reg [WORD_BITS];
    logic [WORD_BITS-1:0] quo_reg [WORD_BITS];
    logic [DSW-1:0]       ds_reg  [WORD_BITS];
    hbfc_flags_t          flg_reg [WORD_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[WORD_BITS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < WORD_BITS; k++) begin : g_stage
        logic [RW-1:0]        rem_src, shifted, rem_next;
        logic [RW:0]          trial;
        logic [WORD_BITS-1:0] low_src, quo_src;
        logic [DSW-1:0]       ds_src;
        hbfc_flags_t          flg_src;
        logic                 qbit;

        if (k == 0) begin : g_first
            assign rem_src = in_rem;
            assign low_src = in_low;
            assign quo_src = '0;
            assign ds_src  = in_ds;
            assign flg_src = in_flags;
        end else begin : g_next
            assign rem_src = rem_reg[k-1];
            assign low_src = low_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign ds_src  = ds_reg[k-1];
            assign flg_src = flg_reg[k-1];
        end

        always_comb begin
            shifted  = {rem_src[RW-2:0], low_src[WORD_BITS-1]};
            trial    = {1'b0, shifted} - (RW + 1)'(ds_src);
            qbit     = !trial[RW];
            rem_next = qbit ? trial[RW-1:0] : shifted;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_src << 1;
                quo_reg[k] <= {quo_src[WORD_BITS-2:0], qbit};
                ds_reg[k]  <= ds_src;
                flg_reg[k] <= flg_src;
            end
        end
    end

    assign out_valid = vld_reg[WORD_BITS-1];
    assign out_quo   = quo_reg[WORD_BITS-1];
    assign out_flags = flg_reg[WORD_BITS-1];

endmodule

### rtl/hll_boundary_flux_correction.sv
// Top level: config register, front pipeline, divider, output register and skid word.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  s_       | in  | s_tvalid / s_tready  | s_tdata: 8 signed words, state/flux/speeds
//  m_       | out | m_tvalid / m_tready  | m_tdata: correction; m_tuser: flags
//  cfg_w    | in  | cfg_wvalid/cfg_wready| cfg_wdata: formulation (0 weak, 1 strong)
//
//  One word per cycle while the skid word is empty. A word passes seven front
//  stages, one divider stage per quotient bit, and the output register.
//  Reset clears the valid bits, including the skid word's, and sets formulation (weak).
//  s_tready is registered; the whole pipeline freezes only once the skid word is
//  full behind a stalled output word.
`timescale 1ns / 1ps

module hll_boundary_flux_correction #(
    parameter int WORD_BITS = hbfc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = hbfc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // state_inside, state_outside, flux_inside, flux_outside, out_speed_inside,
    // in_speed_inside, out_speed_outside, in_speed_outside (lowest first)
    input  logic [((8*WORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // correction
    output logic [((WORD_BITS+7)/8)*8-1:0]        m_tdata,
    // degenerate, saturated (lowest first)
    output logic [hbfc_pkg::USER_W-1:0]           m_tuser,
    input  logic                                  cfg_wvalid,
    output logic                                  cfg_wready,
    input  logic                                  cfg_wdata
);
    import hbfc_pkg::*;

    localparam int M_TDATA_W = ((WORD_BITS + 7) / 8) * 8;
    localparam int DSW       = WORD_BITS + FRAC_BITS + 1;
    localparam int RW        = WORD_BITS + FRAC_BITS + 2;
    localparam logic [WORD_BITS-1:0] CORR_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] CORR_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                 form_reg;
    logic                 en, pop;
    logic                 f_valid, d_valid;
    logic [RW-1:0]        f_rem;
    logic [WORD_BITS-1:0] f_low, d_quo;
    logic [DSW-1:0]       f_ds;
    hbfc_flags_t          f_flags, d_flags;

    logic [WORD_BITS-1:0] res_corr;
    logic [USER_W-1:0]    res_user;

    logic                 out_vld_reg, out_vld_next;
    logic                 skid_vld_reg, skid_vld_next;
    logic                 load_out, load_skid;
    logic [WORD_BITS-1:0] out_corr_reg, skid_corr_reg;
    logic [USER_W-1:0]    out_user_reg, skid_user_reg;

    assign cfg_wready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            form_reg <= FORM_WEAK;
        end else if (cfg_wvalid) begin
            form_reg <= cfg_wdata;
        end
    end

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign pop      = en && d_valid;

    hbfc_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (s_tvalid),
        .formulation       (form_reg),
        .state_inside      (s_tdata[0*WORD_BITS +: WORD_BITS]),
        .state_outside     (s_tdata[1*WORD_BITS +: WORD_BITS]),
        .flux_inside       (s_tdata[2*WORD_BITS +: WORD_BITS]),
        .flux_outside      (s_tdata[3*WORD_BITS +: WORD_BITS]),
        .out_speed_inside  (s_tdata[4*WORD_BITS +: WORD_BITS]),
        .in_speed_inside   (s_tdata[5*WORD_BITS +: WORD_BITS]),
        .out_speed_outside (s_tdata[6*WORD_BITS +: WORD_BITS]),
        .in_speed_outside  (s_tdata[7*WORD_BITS +: WORD_BITS]),
        .out_valid         (f_valid),
        .out_rem           (f_rem),
        .out_low           (f_low),
        .out_ds            (f_ds),
        .out_flags         (f_flags)
    );

    hbfc_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_rem    (f_rem),
        .in_low    (f_low),
        .in_ds     (f_ds),
        .in_flags  (f_flags),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_flags (d_flags)
    );

    always_comb begin
        if (d_flags.degenerate) begin
            res_corr = '0;
        end else if (d_flags.sat) begin
            res_corr = d_flags.neg ? CORR_MIN : CORR_MAX;
        end else begin
            res_corr = d_flags.neg ? -d_quo : d_quo;
        end
        res_user                  = '0;
        res_user[USER_DEGENERATE] = d_flags.degenerate;
        res_user[USER_SATURATED]  = d_flags.sat;
    end

    always_comb begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        if (!out_vld_reg || m_tready) begin
            out_vld_next  = skid_vld_reg || pop;
            skid_vld_next = 1'b0;
            load_out      = 1'b1;
        end else if (pop) begin
            skid_vld_next = 1'b1;
            load_skid     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_corr_reg <= skid_vld_reg ? skid_corr_reg : res_corr;
            out_user_reg <= skid_vld_reg ? skid_user_reg : res_user;
        end
        if (load_skid) begin
            skid_corr_reg <= res_corr;
            skid_user_reg <= res_user;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'(out_corr_reg);
    assign m_tuser  = out_user_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held without an output word");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_tready && d_valid && en) |=> skid_vld_reg)
        else $error("word arriving behind stalled output not captured");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_user_reg[USER_DEGENERATE])
            |-> (out_corr_reg == '0) && !out_user_reg[USER_SATURATED])
        else $error("degenerate word with nonzero correction or clip flag");

    a_sat_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_user_reg[USER_SATURATED])
            |-> (out_corr_reg == CORR_MAX) || (out_corr_reg == CORR_MIN))
        else $error("clipped correction not at a range bound");

endmodule

### sim/tb.sv
// Self-checking testbench for the HLL boundary flux correction pipeline.
`timescale 1ns / 1ps

module tb;
    import hbfc_pkg::*;

    localparam int WB        = WORD_BITS_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int S_DATA_W  = ((8*WB+7)/8)*8;
    localparam int M_DATA_W  = ((WB+7)/8)*8;
    localparam int LATENCY   = WB + 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AFTER = 200;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_M1  = 32'hFFFF_FFFF;
    localparam logic signed [127:0] CORR_HI = 128'sd2147483647;
    localparam logic signed [127:0] CORR_LO = -128'sd2147483648;

    // first member is the top of the word
    typedef struct packed {
        logic [WB-1:0] in_speed_outside;
        logic [WB-1:0] out_speed_outside;
        logic [WB-1:0] in_speed_inside;
        logic [WB-1:0] out_speed_inside;
        logic [WB-1:0] flux_outside;
        logic [WB-1:0] flux_inside;
        logic [WB-1:0] state_outside;
        logic [WB-1:0] state_inside;
    } face_point_t;

    typedef struct {
        logic [WB-1:0] correction;
        logic          degenerate;
        logic          saturated;
    } correction_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_tvalid   = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata    = '0;
    logic                m_tvalid;
    logic                m_tready   = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [USER_W-1:0]   m_tuser;
    logic                cfg_wvalid = 1'b0;
    logic                cfg_wready;
    logic                cfg_wdata  = 1'b0;

    face_point_t face_pending_q[$];
    correction_t corr_expect_q[$];

    logic     formulation_q = FORM_WEAK;
    logic     s_taken       = 1'b0;
    int       errors        = 0;
    int       faces_in      = 0;
    int       results_seen  = 0;
    int       degen_seen    = 0;
    int       sat_seen      = 0;
    int       cfg_writes    = 0;
    int       idle_cycles   = 0;
    int       burst_left    = 1;
    int       gap_left      = 0;
    int       rx_left       = 0;
    int       hold_left     = 0;
    bit       hold_done     = 1'b0;
    rx_mode_t rx_mode       = RX_OPEN;

    hll_boundary_flux_correction u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic correction_t hll_correction(input face_point_t fp, input logic form);
        logic signed [127:0] ui, ue, fi, fe, osi, isi, ose, ise;
        logic signed [127:0] lmax, lmin, span, num, q;
        correction_t r;
        ui   = $signed(fp.state_inside);
        ue   = $signed(fp.state_outside);
        fi   = $signed(fp.flux_inside);
        fe   = $signed(fp.flux_outside);
        osi  = $signed(fp.out_speed_inside);
        isi  = $signed(fp.in_speed_inside);
        ose  = $signed(fp.out_speed_outside);
        ise  = $signed(fp.in_speed_outside);
        lmax = 0;
        if (osi > lmax) lmax = osi;
        if (-ise > lmax) lmax = -ise;
        lmin = 0;
        if (isi < lmin) lmin = isi;
        if (-ose < lmin) lmin = -ose;
        span = lmax - lmin;
        r.degenerate = 1'b0;
        r.saturated  = 1'b0;
        if (span == 0) begin
            r.correction = '0;
            r.degenerate = 1'b1;
            return r;
        end
        if (form == FORM_WEAK)
            num = lmax * fi + lmin * fe;
        else
            num = lmin * (fi + fe);
        num = (num <<< FB) + lmax * lmin * (ue - ui);
        // signed division truncates toward zero
        q = num / (span <<< FB);
        if (q > CORR_HI) begin
            q = CORR_HI;
            r.saturated = 1'b1;
        end
        if (q < CORR_LO) begin
            q = CORR_LO;
            r.saturated = 1'b1;
        end
        r.correction = q[WB-1:0];
        return r;
    endfunction

    function automatic logic [31:0] sample_value();
        int pick;
        logic [31:0] v;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 4))
                0: v = W_MAX;
                1: v = W_MIN;
                2: v = 32'h0;
                3: v = 32'h1;
                default: v = W_M1;
            endcase
        end else if (pick <= 2) begin
            v = $urandom;
        end else begin
            v = $urandom_range(0, 32 << 16);
            if ($urandom_range(0, 1)) v = -v;
        end
        return v;
    endfunction

    task automatic queue_face(input logic [31:0] si, so, fi, fo, osi, isi, oso, iso);
        face_point_t fp;
        fp.state_inside      = si;
        fp.state_outside     = so;
        fp.flux_inside       = fi;
        fp.flux_outside      = fo;
        fp.out_speed_inside  = osi;
        fp.in_speed_inside   = isi;
        fp.out_speed_outside = oso;
        fp.in_speed_outside  = iso;
        face_pending_q.push_back(fp);
    endtask

    task automatic queue_directed();
        // zero speeds, then speeds whose signs both clamp to zero
        queue_face(0, 0, 0, 0, 0, 0, 0, 0);
        queue_face(W_MAX, W_MIN, W_MAX, W_MIN, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
        queue_face(Q_ONE, 2*Q_ONE, Q_ONE/2, -Q_ONE/2, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
        // negative quotient with a fraction (weak formulation), truncated toward zero
        queue_face(32'h1, 32'h0, W_M1, 32'h3, 3*Q_ONE, -Q_ONE, 32'h1, -7);
        queue_face(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
        queue_face(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
        queue_face(W_MIN, W_MAX, W_MAX, W_MAX, 32'h1, -32'h1, 32'h1, -32'h1);
        queue_face(W_MAX, W_MIN, W_MIN, W_MIN, 32'h1, -32'h1, 32'h1, -32'h1);
        // one-sided fan: lower bound clamps to zero
        queue_face(Q_ONE, -Q_ONE, 5*Q_ONE, 3*Q_ONE, 2*Q_ONE, Q_ONE, -Q_ONE, -Q_ONE);
        // upper bound taken from the exterior ingoing speed
        queue_face(2*Q_ONE, Q_ONE, -Q_ONE, 4*Q_ONE, Q_ONE, -Q_ONE, Q_ONE, -5*Q_ONE);
        // lower bound taken from the exterior outgoing speed
        queue_face(-Q_ONE, 3*Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, 7*Q_ONE, 0);
        queue_face(0, 0, W_MAX, W_MAX, 32'h1, -32'h1, 0, 0);
        queue_face(W_MIN, W_MAX, 0, 0, W_MAX, W_MIN, W_MAX, W_MIN);
    endtask

    task automatic queue_random(input int n);
        logic [31:0] osi, isi, oso, iso;
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                osi = -$urandom_range(0, 8 << 16);
                isi = $urandom_range(0, 8 << 16);
                oso = -$urandom_range(0, 8 << 16);
                iso = $urandom_range(0, 8 << 16);
                queue_face(sample_value(), sample_value(), sample_value(), sample_value(),
                           osi, isi, oso, iso);
            end else if (kind <= 3) begin
                queue_face($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            end else begin
                if (kind == 4) begin
                    osi = sample_value();
                    isi = sample_value();
                    oso = sample_value();
                    iso = sample_value();
                end else begin
                    osi = $urandom_range(0, 16 << 16);
                    isi = -$urandom_range(0, 16 << 16);
                    oso = $urandom_range(0, 16 << 16);
                    iso = -$urandom_range(0, 16 << 16);
                end
                queue_face(sample_value(), sample_value(), sample_value(), sample_value(),
                           osi, isi, oso, iso);
            end
        end
    endtask

    task automatic drain();
        while (face_pending_q.size() != 0 || s_tvalid || corr_expect_q.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic set_formulation(input logic form);
        drain();
        @(negedge aclk);
        cfg_wvalid <= 1'b1;
        cfg_wdata  <= form;
        do @(posedge aclk); while (!cfg_wready);
        @(negedge aclk);
        cfg_wvalid <= 1'b0;
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (face_pending_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= face_pending_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 80);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= $urandom_range(0, 1);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        correction_t e;
        bit m_fire, c_fire;
        s_taken = s_tvalid && s_tready;
        m_fire  = m_tvalid && m_tready;
        c_fire  = cfg_wvalid && cfg_wready;
        if (aresetn) begin
            if (s_taken) begin
                corr_expect_q.push_back(hll_correction(face_point_t'(s_tdata), formulation_q));
                faces_in++;
            end
            if (c_fire) begin
                formulation_q = cfg_wdata;
                cfg_writes++;
            end
            if (m_fire) begin
                results_seen++;
                if (corr_expect_q.size() == 0) begin
                    $display("%0t: unexpected word: correction %h flags %b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    e = corr_expect_q.pop_front();
                    degen_seen += e.degenerate;
                    sat_seen   += e.saturated;
                    if (m_tdata[WB-1:0] !== e.correction) begin
                        $display("%0t: correction mismatch: expected %h, actual %h",
                                 $time, e.correction, m_tdata[WB-1:0]);
                        errors++;
                    end
                    if (m_tuser[USER_DEGENERATE] !== e.degenerate) begin
                        $display("%0t: degenerate mismatch: expected %b, actual %b",
                                 $time, e.degenerate, m_tuser[USER_DEGENERATE]);
                        errors++;
                    end
                    if (m_tuser[USER_SATURATED] !== e.saturated) begin
                        $display("%0t: saturated mismatch: expected %b, actual %b",
                                 $time, e.saturated, m_tuser[USER_SATURATED]);
                        errors++;
                    end
                end
            end
            if (s_taken || m_fire || c_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout, %0d words still expected", $time, corr_expect_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_formulation(FORM_WEAK);
        queue_directed();
        set_formulation(FORM_STRONG);
        queue_directed();
        set_formulation(FORM_WEAK);
        queue_random(150);
        set_formulation(FORM_STRONG);
        queue_random(150);
        set_formulation(FORM_WEAK);
        queue_random(100);
        set_formulation(FORM_STRONG);
        queue_random(100);

        drain();
        repeat (LATENCY) @(posedge aclk);
        if (corr_expect_q.size() != 0) begin
            $display("%0t: %0d words never arrived", $time, corr_expect_q.size());
            errors++;
        end
        $display("Sent %0d face points over %0d formulation writes; %0d results checked",
                 faces_in, cfg_writes, results_seen);
        $display("Degenerate results: %0d, saturated results: %0d, mismatches: %0d",
                 degen_seen, sat_seen, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
